// File: rtl/gss_pkg.sv
// Shared types and constants for the automatic gear shift sequencer.
// Used by gss_csr, auto_gear_shift_sequencer and gss_checker; depends on nothing.
`default_nettype none

package gss_pkg;

   // Field widths
   localparam int SPEED_W  = 16;
   localparam int PEDAL_W  = 8;
   localparam int RPM_W    = 14;
   localparam int GEAR_W   = 5;
   localparam int TICK_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int STAND_W  = 15;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [GEAR_W-1:0] gear_type;

   localparam gear_type GEAR_REVERSE = -5'sd1;
   localparam gear_type GEAR_NEUTRAL = 5'sd0;
   localparam gear_type GEAR_FIRST   = 5'sd1;

   // Highest forward gear the hardware supports
   localparam logic [COUNT_W-1:0] MAX_GEARS = 4'd8;

   // Pedal pressed above a tenth of full travel, clutch closed above nine tenths
   localparam logic [PEDAL_W-1:0] PEDAL_MIN  = 8'd25;
   localparam logic [PEDAL_W-1:0] CLUTCH_MIN = 8'd229;

   localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHIFT_UP_RPM     = 4'd0,
      CSR_SHIFT_DOWN_RPM   = 4'd1,
      CSR_SHIFT_TICKS      = 4'd2,
      CSR_GEAR_COUNT       = 4'd3,
      CSR_AUTOMATIC_MODE   = 4'd4,
      CSR_STANDSTILL_SPEED = 4'd5,
      CSR_DWELL_TICKS      = 4'd6,
      CSR_COOLDOWN_TICKS   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [RPM_W-1:0]   shift_up_rpm;
      logic [RPM_W-1:0]   shift_down_rpm;
      logic [TICK_W-1:0]  shift_ticks;
      logic [COUNT_W-1:0] gear_count;
      logic               automatic_mode;
      logic [STAND_W-1:0] standstill_speed;
      logic [TICK_W-1:0]  dwell_ticks;
      logic [TICK_W-1:0]  cooldown_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shift_up_rpm:     14'd6000,
      shift_down_rpm:   14'd2500,
      shift_ticks:      8'd0,
      gear_count:       4'd6,
      automatic_mode:   1'b1,
      standstill_speed: 15'd60,
      dwell_ticks:      8'd30,
      cooldown_ticks:   8'd50
   };

endpackage

`default_nettype wire

// File: rtl/gss_csr.sv
// Configuration register file of the gear shift sequencer.
// Depends on gss_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module gss_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [gss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [gss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output gss_pkg::cfg_type                cfg
);
   import gss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always able to take a word
   assign csr_ready = 1'b1;

   // Decode the write, drop unknown indexes, mask high bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHIFT_UP_RPM:     cfg_in.shift_up_rpm     = csr_wdata[RPM_W-1:0];
            CSR_SHIFT_DOWN_RPM:   cfg_in.shift_down_rpm   = csr_wdata[RPM_W-1:0];
            CSR_SHIFT_TICKS:      cfg_in.shift_ticks      = csr_wdata[TICK_W-1:0];
            CSR_GEAR_COUNT:       cfg_in.gear_count       = csr_wdata[COUNT_W-1:0];
            CSR_AUTOMATIC_MODE:   cfg_in.automatic_mode   = csr_wdata[0];
            CSR_STANDSTILL_SPEED: cfg_in.standstill_speed = csr_wdata[STAND_W-1:0];
            CSR_DWELL_TICKS:      cfg_in.dwell_ticks      = csr_wdata[TICK_W-1:0];
            CSR_COOLDOWN_TICKS:   cfg_in.cooldown_ticks   = csr_wdata[TICK_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/auto_gear_shift_sequencer.sv
// Automatic gear shift sequencer: input register, gear decision logic, result register.
// Two register stages, input then result; the gear state updates as a word moves to
// the result. Throughput: one word per cycle unless rsp_stall holds the result word.
// Reset (synchronous): neutral, no shift, counters cleared, since-shift count saturated,
// configuration at its defaults; both pipeline stages empty.
// Depends on gss_pkg and gss_csr.
`default_nettype none

module auto_gear_shift_sequencer (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  signed [gss_pkg::SPEED_W-1:0] req_speed_forward,
   input  wire  [gss_pkg::PEDAL_W-1:0]     req_throttle_pedal,
   input  wire  [gss_pkg::PEDAL_W-1:0]     req_brake_pedal,
   input  wire  [gss_pkg::RPM_W-1:0]       req_shaft_rpm,
   input  wire  [gss_pkg::PEDAL_W-1:0]     req_clutch_level,
   // response channel
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic signed [gss_pkg::GEAR_W-1:0] rsp_gear_now,
   output logic                            rsp_shift_active,
   output logic [gss_pkg::PEDAL_W-1:0]     rsp_drive_pedal,
   output logic [gss_pkg::PEDAL_W-1:0]     rsp_stop_pedal,
   // configuration channel
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [gss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [gss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gss_pkg::*;

   cfg_type cfg;

   gss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, out_load;

   assign out_load    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !out_load;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Input register
   logic [SPEED_W-1:0] speed_ff;
   logic [PEDAL_W-1:0] thr_ff, brk_ff, clu_ff;
   logic [RPM_W-1:0]   rpm_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         speed_ff <= req_speed_forward;
         thr_ff   <= req_throttle_pedal;
         brk_ff   <= req_brake_pedal;
         rpm_ff   <= req_shaft_rpm;
         clu_ff   <= req_clutch_level;
      end
   end

   // Gear state
   gear_type          gear_ff, gear_in, target_ff, target_in, goal;
   logic              shifting_ff, shifting_in, want;
   logic [TICK_W-1:0] countdown_ff, countdown_in;
   logic [TICK_W-1:0] stand_ff, stand_in, since_ff, since_in;

   // Speed magnitude, one bit wider so the most negative speed is never a standstill
   logic [SPEED_W:0]   mag;
   logic               stopped, dwelt, thr_on, brk_on, clutch_on, fwd, rev;
   logic [COUNT_W-1:0] top;

   assign mag = speed_ff[SPEED_W-1] ? ({1'b0, ~speed_ff} + 17'd1) : {1'b0, speed_ff};
   assign stopped   = mag < {2'b00, cfg.standstill_speed};
   assign thr_on    = thr_ff > PEDAL_MIN;
   assign brk_on    = brk_ff > PEDAL_MIN;
   assign clutch_on = clu_ff > CLUTCH_MIN;
   assign fwd       = gear_ff > GEAR_NEUTRAL;
   assign rev       = gear_ff[GEAR_W-1];

   // Clamp the configured gear count to the supported range
   always_comb begin
      priority if (cfg.gear_count == '0) begin
         top = 4'd1;
      end else if (cfg.gear_count > MAX_GEARS) begin
         top = MAX_GEARS;
      end else begin
         top = cfg.gear_count;
      end
   end

   // Next gear state for the word moving to the result register
   always_comb begin
      stand_in     = stopped ? ((stand_ff == TICK_MAX) ? stand_ff : stand_ff + 8'd1) : '0;
      since_in     = (since_ff == TICK_MAX) ? since_ff : since_ff + 8'd1;
      dwelt        = stand_in > cfg.dwell_ticks;
      gear_in      = gear_ff;
      target_in    = target_ff;
      shifting_in  = shifting_ff;
      countdown_in = countdown_ff;
      want         = 1'b0;
      goal         = GEAR_NEUTRAL;

      priority if (shifting_ff) begin
         // finish or hold the running shift
         if (countdown_ff <= 8'd1) begin
            countdown_in = '0;
            shifting_in  = 1'b0;
            gear_in      = target_ff;
            since_in     = '0;
         end else begin
            countdown_in = countdown_ff - 8'd1;
         end
      end else if (gear_ff == GEAR_NEUTRAL) begin
         want = 1'b1;
         goal = GEAR_FIRST;
      end else if (cfg.automatic_mode) begin
         priority if (dwelt && fwd && brk_on && !thr_on) begin
            want = 1'b1;
            goal = GEAR_REVERSE;
         end else if (dwelt && rev && thr_on && !brk_on) begin
            want = 1'b1;
            goal = GEAR_FIRST;
         end else if (fwd && clutch_on && (since_in > cfg.cooldown_ticks)) begin
            if ((rpm_ff > cfg.shift_up_rpm) && (gear_ff < $signed({1'b0, top}))) begin
               want = 1'b1;
               goal = gear_ff + GEAR_FIRST;
            end else if ((rpm_ff < cfg.shift_down_rpm) && (gear_ff > GEAR_FIRST)) begin
               want = 1'b1;
               goal = gear_ff - GEAR_FIRST;
            end
         end else begin
            want = 1'b0;
         end
      end else begin
         want = 1'b0;
      end

      // start a shift: keep the current gear while the countdown runs, or change at once
      if (want && (goal != gear_ff)) begin
         target_in = goal;
         if (cfg.shift_ticks != '0) begin
            shifting_in  = 1'b1;
            countdown_in = cfg.shift_ticks;
         end else begin
            gear_in  = goal;
            since_in = '0;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gear_ff      <= GEAR_NEUTRAL;
         target_ff    <= GEAR_NEUTRAL;
         shifting_ff  <= 1'b0;
         countdown_ff <= '0;
         stand_ff     <= '0;
         since_ff     <= TICK_MAX;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            gear_ff      <= gear_in;
            target_ff    <= target_in;
            shifting_ff  <= shifting_in;
            countdown_ff <= countdown_in;
            stand_ff     <= stand_in;
            since_ff     <= since_in;
         end
      end
   end

   // Result register; swap the pedals in reverse
   gear_type           gear_out_ff;
   logic               shift_out_ff;
   logic [PEDAL_W-1:0] drive_out_ff, stop_out_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         gear_out_ff  <= gear_in;
         shift_out_ff <= shifting_in;
         drive_out_ff <= gear_in[GEAR_W-1] ? brk_ff : thr_ff;
         stop_out_ff  <= gear_in[GEAR_W-1] ? thr_ff : brk_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gear_now     = gear_out_ff;
   assign rsp_shift_active = shift_out_ff;
   assign rsp_drive_pedal  = drive_out_ff;
   assign rsp_stop_pedal   = stop_out_ff;

endmodule

`default_nettype wire

// File: rtl/gss_checker.sv
// Port-level checks for auto_gear_shift_sequencer, attached by the bind below.
// Depends on gss_pkg for field widths and gear constants.
`default_nettype none

module gss_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire signed [gss_pkg::GEAR_W-1:0]   rsp_gear_now,
   input wire                                rsp_shift_active,
   input wire                                csr_ready
);
   import gss_pkg::*;

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gear_now)
         && $stable(rsp_shift_active))
      else $error("stalled response word changed");

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Gear stays within reverse to the highest supported forward gear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gear_now == GEAR_REVERSE) ||
         ((rsp_gear_now >= GEAR_NEUTRAL) && (rsp_gear_now <= $signed({1'b0, MAX_GEARS}))))
      else $error("gear out of range");

   // Configuration port never back-pressures
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind auto_gear_shift_sequencer gss_checker u_gss_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_gear_now     (rsp_gear_now),
   .rsp_shift_active (rsp_shift_active),
   .csr_ready        (csr_ready)
);

`default_nettype wire
